// ----- sv/lpfs_pkg.sv -----
// Shared types, constants and digit stroke tables for the LED panel scanner.
package lpfs_pkg;

  localparam int DEF_PANEL_COLS = 32;
  localparam int DEF_ROW_PAIRS  = 16;

  // Stroke coordinates: a 5-bit field plus an offset inside the digit cell
  localparam int ROW_W = 6;
  localparam int COL_W = 6;

  localparam int CELL_ROWS = 5;
  localparam int CELL_COLS = 3;

  localparam int SEG_A = 0;
  localparam int SEG_B = 1;
  localparam int SEG_C = 2;
  localparam int SEG_D = 3;
  localparam int SEG_E = 4;
  localparam int SEG_F = 5;
  localparam int SEG_G = 6;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_DIGIT = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [2:0]       color;
  } wr_req_t;

  // Segment set per digit, bit SEG_A upward
  function automatic logic [6:0] digit_segments(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1100111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

  // True when the cell at (dr, dc) lies on a lit stroke
  function automatic logic cell_lit(input logic [6:0] s, input logic [2:0] dr,
                                    input logic [1:0] dc);
    logic top_half;
    logic bot_half;
    logic right;
    logic left;
    top_half = (dr <= 3'd2);
    bot_half = (dr >= 3'd2);
    right    = (dc == 2'(CELL_COLS - 1));
    left     = (dc == 2'd0);
    return (s[SEG_A] && dr == 3'd0) ||
           (s[SEG_D] && dr == 3'(CELL_ROWS - 1)) ||
           (s[SEG_G] && dr == 3'd2) ||
           (s[SEG_B] && right && top_half) ||
           (s[SEG_C] && right && bot_half) ||
           (s[SEG_E] && left && bot_half) ||
           (s[SEG_F] && left && top_half);
  endfunction

endpackage

// ----- sv/lpfs_in_if.sv -----
// Input channel: pixel writes, digit draws and scan ticks.
interface lpfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] row;
  logic [4:0] col;
  logic [2:0] color;
  logic [3:0] digit;

  modport source (output valid, action, row, col, color, digit, input ready);
  modport sink   (input valid, action, row, col, color, digit, output ready);
endinterface

// ----- sv/lpfs_out_if.sv -----
// Output channel: one column shift beat per scan tick.
interface lpfs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_address;
  logic [2:0] upper_color;
  logic [2:0] lower_color;
  logic       latch;
  logic       frame_done;

  modport source (output valid, row_address, upper_color, lower_color, latch, frame_done,
                  input ready);
  modport sink   (input valid, row_address, upper_color, lower_color, latch, frame_done,
                  output ready);
endinterface

// ----- sv/lpfs_store.sv -----
// Frame store: upper and lower half memories, clearing sweep, write and scan read ports.
module lpfs_store
  import lpfs_pkg::*;
#(
  parameter int PANEL_COLS = DEF_PANEL_COLS,
  parameter int ROW_PAIRS  = DEF_ROW_PAIRS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wr_req_t                      wr_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(ROW_PAIRS)-1:0] rd_pair_i,
  input  logic [$clog2(PANEL_COLS)-1:0] rd_col_i,
  output logic [2:0]                   upper_o,
  output logic [2:0]                   lower_o,
  output logic                         clearing_o
);

  localparam int RPW   = $clog2(ROW_PAIRS);
  localparam int CW    = $clog2(PANEL_COLS);
  localparam int AW    = RPW + CW;
  localparam int Depth = 1 << AW;
  localparam int RCW   = ((ROW_W > RPW + 1) ? ROW_W : RPW + 1) + 1;
  localparam int CCW   = ((COL_W > CW) ? COL_W : CW) + 1;

  logic [2:0] mem_up [Depth];
  logic [2:0] mem_lo [Depth];

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic [RCW-1:0] row_ext;
  logic [CCW-1:0] col_ext;
  logic           in_panel;
  logic           lower_half;
  logic [RCW-1:0] pair_ext;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [2:0]     wdata;
  logic           we_up, we_lo;

  assign row_ext    = RCW'(wr_i.row);
  assign col_ext    = CCW'(wr_i.col);
  assign in_panel   = (row_ext < RCW'(2 * ROW_PAIRS)) && (col_ext < CCW'(PANEL_COLS));
  assign lower_half = (row_ext >= RCW'(ROW_PAIRS));
  assign pair_ext   = lower_half ? (row_ext - RCW'(ROW_PAIRS)) : row_ext;
  assign raddr      = {rd_pair_i, rd_col_i};

  always_comb begin
    if (clr_q) begin
      waddr = clr_addr_q;
      wdata = 3'd0;
      we_up = 1'b1;
      we_lo = 1'b1;
    end else begin
      waddr = {pair_ext[RPW-1:0], col_ext[CW-1:0]};
      wdata = wr_i.color;
      we_up = wr_i.en && in_panel && !lower_half;
      we_lo = wr_i.en && in_panel && lower_half;
    end
  end

  // Sweep every entry once after reset
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Depth - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_up) begin
      mem_up[waddr] <= wdata;
    end
    if (rd_en_i) begin
      upper_o <= mem_up[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_lo) begin
      mem_lo[waddr] <= wdata;
    end
    if (rd_en_i) begin
      lower_o <= mem_lo[raddr];
    end
  end

  assign clearing_o = clr_q;

endmodule

// ----- sv/lpfs_digit_seq.sv -----
// Digit sequencer: walks the 3x5 cell and issues one write per lit stroke pixel.
module lpfs_digit_seq
  import lpfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [4:0] row_i,
  input  logic [4:0] col_i,
  input  logic [2:0] color_i,
  input  logic [3:0] digit_i,
  output logic       busy_o,
  output wr_req_t    wr_o
);

  logic       busy_q, busy_d;
  logic [2:0] dr_q, dr_d;
  logic [1:0] dc_q, dc_d;
  logic [4:0] row_q, col_q;
  logic [2:0] color_q;
  logic [6:0] seg_q;

  always_comb begin
    busy_d = busy_q;
    dr_d   = dr_q;
    dc_d   = dc_q;
    if (start_i) begin
      busy_d = 1'b1;
      dr_d   = 3'd0;
      dc_d   = 2'd0;
    end else if (busy_q) begin
      if (dc_q == 2'(CELL_COLS - 1)) begin
        dc_d = 2'd0;
        dr_d = dr_q + 3'd1;
        if (dr_q == 3'(CELL_ROWS - 1)) begin
          busy_d = 1'b0;
        end
      end else begin
        dc_d = dc_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dr_q   <= 3'd0;
      dc_q   <= 2'd0;
    end else begin
      busy_q <= busy_d;
      dr_q   <= dr_d;
      dc_q   <= dc_d;
    end
  end

  // Hold the draw request for the whole walk
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      row_q   <= row_i;
      col_q   <= col_i;
      color_q <= color_i;
      seg_q   <= digit_segments(digit_i);
    end
  end

  assign busy_o     = busy_q;
  assign wr_o.en    = busy_q && cell_lit(seg_q, dr_q, dc_q);
  assign wr_o.row   = ROW_W'(row_q) + ROW_W'(dr_q);
  assign wr_o.col   = COL_W'(col_q) + COL_W'(dc_q);
  assign wr_o.color = color_q;

endmodule

// ----- sv/led_panel_framebuffer_scanner.sv -----
// Top level: LED panel frame store with pixel and digit writes and a column scanner.
// Scan tick: the store read and the pending beat are registered, then moved into the output
// registers; one tick per cycle while the output drains. Pixel write: goes straight to the store.
// Digit draw: walks the 15 cells of its 3x5 box in the digit sequencer; no new item is
// taken until the walk is done. Reset: the store memories are swept to zero, one entry of each half per cycle,
// over all 2**(clog2(ROW_PAIRS)+clog2(PANEL_COLS)) entries (512 by default), no input taken meanwhile.
module led_panel_framebuffer_scanner
  import lpfs_pkg::*;
#(
  parameter int PANEL_COLS = DEF_PANEL_COLS,
  parameter int ROW_PAIRS  = DEF_ROW_PAIRS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpfs_in_if.sink   in_i,
  lpfs_out_if.source out_o
);

  localparam int RPW = $clog2(ROW_PAIRS);
  localparam int CW  = $clog2(PANEL_COLS);

  logic       in_acc;
  logic       tick_acc, pixel_acc, digit_acc;
  logic       clearing;
  logic       seq_busy;
  wr_req_t    seq_wr, wr;
  logic [2:0] upper, lower;

  logic [RPW-1:0] scan_row_q, scan_row_d;
  logic [CW-1:0]  scan_col_q, scan_col_d;
  logic           last_col, last_row;
  logic [RPW-1:0] prev_row;

  logic       pend_q, pend_d;
  logic [3:0] pend_addr_q;
  logic       pend_latch_q, pend_done_q;
  logic       move;

  logic       out_valid_q, out_valid_d;
  logic [3:0] out_addr_q;
  logic [2:0] out_up_q, out_lo_q;
  logic       out_latch_q, out_done_q;

  assign move     = pend_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clearing && !seq_busy && (!pend_q || move);
  assign in_acc   = in_i.valid && in_i.ready;

  always_comb begin
    tick_acc  = 1'b0;
    pixel_acc = 1'b0;
    digit_acc = 1'b0;
    case (action_e'(in_i.action))
      ACT_PIXEL: pixel_acc = in_acc;
      ACT_DIGIT: digit_acc = in_acc;
      ACT_TICK:  tick_acc  = in_acc;
      default: ;
    endcase
  end

  always_comb begin
    wr = seq_wr;
    if (pixel_acc) begin
      wr.en    = 1'b1;
      wr.row   = ROW_W'(in_i.row);
      wr.col   = COL_W'(in_i.col);
      wr.color = in_i.color;
    end
  end

  lpfs_digit_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (digit_acc),
    .row_i   (in_i.row),
    .col_i   (in_i.col),
    .color_i (in_i.color),
    .digit_i (in_i.digit),
    .busy_o  (seq_busy),
    .wr_o    (seq_wr)
  );

  lpfs_store #(
    .PANEL_COLS (PANEL_COLS),
    .ROW_PAIRS  (ROW_PAIRS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_en_i    (tick_acc),
    .rd_pair_i  (scan_row_q),
    .rd_col_i   (scan_col_q),
    .upper_o    (upper),
    .lower_o    (lower),
    .clearing_o (clearing)
  );

  assign last_col = (scan_col_q == CW'(PANEL_COLS - 1));
  assign last_row = (scan_row_q == RPW'(ROW_PAIRS - 1));
  assign prev_row = (scan_row_q == '0) ? RPW'(ROW_PAIRS - 1) : scan_row_q - RPW'(1);

  // Advance the scan position on each tick
  always_comb begin
    scan_row_d = scan_row_q;
    scan_col_d = scan_col_q;
    if (tick_acc) begin
      if (last_col) begin
        scan_col_d = '0;
        scan_row_d = last_row ? '0 : scan_row_q + RPW'(1);
      end else begin
        scan_col_d = scan_col_q + CW'(1);
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (tick_acc) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q  <= '0;
      scan_col_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_row_q  <= scan_row_d;
      scan_col_q  <= scan_col_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      pend_addr_q  <= 4'(prev_row);
      pend_latch_q <= last_col;
      pend_done_q  <= last_col && last_row;
    end
    if (move) begin
      out_addr_q  <= pend_addr_q;
      out_up_q    <= upper;
      out_lo_q    <= lower;
      out_latch_q <= pend_latch_q;
      out_done_q  <= pend_done_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.row_address = out_addr_q;
  assign out_o.upper_color = out_up_q;
  assign out_o.lower_color = out_lo_q;
  assign out_o.latch       = out_latch_q;
  assign out_o.frame_done  = out_done_q;

endmodule
